### rtl/bexr_pkg.sv
`timescale 1ns / 1ps

package bexr_pkg;

  localparam int unsigned Buttons   = 5;
  localparam int unsigned PinBits   = 2 * Buttons;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned CntBits   = $clog2(WordBits + 1);

  localparam logic [WordBits-1:0] GenReset = 32'h9E37_79B9;
  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  localparam logic ActPoll = 1'b0;
  localparam logic ActDraw = 1'b1;

  typedef struct packed {
    logic                action;
    logic [PinBits-1:0]  pin_levels;
    logic [WordBits-1:0] timestamp_us;
    logic [WordBits-1:0] range_limit;
  } in_req_t;

  typedef struct packed {
    logic [Buttons-1:0]  held;
    logic [Buttons-1:0]  newly_pressed;
    logic [WordBits-1:0] random_value;
    logic [WordBits-1:0] random_below;
    logic                range_error;
  } out_rsp_t;

  function automatic logic [WordBits-1:0] xorshift_step(input logic [WordBits-1:0] s);
    logic [WordBits-1:0] x;
    x = s ^ (s << ShiftA);
    x = x ^ (x >> ShiftB);
    x = x ^ (x << ShiftC);
    return x;
  endfunction

endpackage

### rtl/bexr_mod_serial.sv
`timescale 1ns / 1ps

module bexr_mod_serial (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bexr_pkg::WordBits-1:0] dividend_i,
  input  logic [bexr_pkg::WordBits-1:0] divisor_i,
  output logic                          done_o,
  output logic [bexr_pkg::WordBits-1:0] rem_o
);
  import bexr_pkg::*;

  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [WordBits-1:0] num_q, num_d;
  logic [WordBits-1:0] den_q, den_d;
  logic [WordBits-1:0] rem_q, rem_d;
  logic [WordBits:0]   trial;
  logic [WordBits:0]   diff;

  assign trial = {rem_q, num_q[WordBits-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d = CntBits'(WordBits);
      num_d = dividend_i;
      den_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      // one quotient bit: restore unless the trial covers the divisor
      cnt_d = cnt_q - CntBits'(1);
      num_d = {num_q[WordBits-2:0], 1'b0};
      if (diff[WordBits]) begin
        rem_d = trial[WordBits-1:0];
      end else begin
        rem_d = diff[WordBits-1:0];
      end
      done_d = (cnt_q == CntBits'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### rtl/button_edge_xorshift_rng.sv
`timescale 1ns / 1ps
// Poll request: the result goes to the done state, then into the output register once that
// register is empty or not stalled; the next request is accepted after the return to idle.
// Draw request with a nonzero range: it waits in the run state for the bit-serial remainder
// unit (one quotient bit per cycle over 32 bits); with a zero range it flags range_error
// and skips that unit. One request in flight; a finished result waits in the result register
// until the output register can take it. Asynchronous active-low reset clears button history,
// priming and output valid, and loads the generator with 0x9E3779B9.

module button_edge_xorshift_rng (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bexr_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bexr_pkg::out_rsp_t  out_rsp_o
);
  import bexr_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [Buttons-1:0]  prev_q, prev_d;
  logic                primed_q, primed_d;
  logic [WordBits-1:0] gen_q, gen_d;
  logic                out_valid_q, out_valid_d;
  out_rsp_t            res_q, res_d;
  out_rsp_t            out_q, out_d;

  logic                in_fire;
  logic                load_out;
  logic [Buttons-1:0]  pressed;
  logic [Buttons-1:0]  edges;
  logic [WordBits-1:0] next_gen;
  logic                div_start;
  logic                div_done;
  logic [WordBits-1:0] div_rem;

  assign in_fire  = in_valid_i && (state_q == StIdle);
  assign load_out = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  assign pressed  = ~in_req_i.pin_levels[Buttons-1:0] | ~in_req_i.pin_levels[PinBits-1:Buttons];
  assign edges    = primed_q ? (pressed & ~prev_q) : '0;
  assign next_gen = xorshift_step(gen_q);

  assign div_start = in_fire && (in_req_i.action == ActDraw) && (in_req_i.range_limit != '0);

  bexr_mod_serial u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (next_gen),
    .divisor_i  (in_req_i.range_limit),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    primed_d    = primed_q;
    gen_d       = gen_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          res_d = '0;
          if (in_req_i.action == ActPoll) begin
            res_d.held          = pressed;
            res_d.newly_pressed = edges;
            prev_d              = pressed;
            primed_d            = 1'b1;
            if (edges != '0) begin
              gen_d = gen_q ^ in_req_i.timestamp_us;
            end
            state_d = StDone;
          end else begin
            gen_d              = next_gen;
            res_d.random_value = next_gen;
            if (in_req_i.range_limit == '0) begin
              res_d.range_error = 1'b1;
              state_d           = StDone;
            end else begin
              state_d = StRun;
            end
          end
        end
      end
      StRun: begin
        if (div_done) begin
          res_d.random_below = div_rem;
          state_d            = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '0;
      primed_q    <= 1'b0;
      gen_q       <= GenReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      primed_q    <= primed_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### verif/tb_button_edge_xorshift_rng.sv
`timescale 1ns / 1ps

module tb_button_edge_xorshift_rng;
  import bexr_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldCycles = 400;

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  in_req_t  pending_req_q[$];
  out_rsp_t expected_rsp_q[$];
  out_rsp_t want;

  logic [Buttons-1:0]  model_prev_buttons = '0;
  logic                model_primed = 1'b0;
  logic [WordBits-1:0] model_rng = GenReset;

  logic [PinBits-1:0]  stick_pins = '1;
  logic [WordBits-1:0] stamp_clock = '0;

  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          holdoff_done = 1'b0;
  int          stall_phase = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned idle_cycles = 0;

  int n_errors = 0;
  int n_results = 0;
  int n_polls = 0;
  int n_draws = 0;
  int n_mixes = 0;
  int n_zero_ranges = 0;
  int n_zero_draws = 0;

  button_edge_xorshift_rng dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, exp_val);
    n_errors++;
  endtask

  task automatic predict_rng_result(input in_req_t r);
    out_rsp_t            res;
    logic [Buttons-1:0]  pressed;
    logic [Buttons-1:0]  edges;
    logic [WordBits-1:0] x;
    res = '0;
    if (r.action == ActPoll) begin
      pressed = ~r.pin_levels[Buttons-1:0] | ~r.pin_levels[PinBits-1:Buttons];
      edges = model_primed ? (pressed & ~model_prev_buttons) : '0;
      if (edges != '0) begin
        model_rng ^= r.timestamp_us;
        n_mixes++;
      end
      model_primed = 1'b1;
      model_prev_buttons = pressed;
      res.held = pressed;
      res.newly_pressed = edges;
      n_polls++;
    end else begin
      x = model_rng;
      x ^= x << ShiftA;
      x ^= x >> ShiftB;
      x ^= x << ShiftC;
      model_rng = x;
      res.random_value = x;
      if (r.range_limit == '0) begin
        res.range_error = 1'b1;
        n_zero_ranges++;
      end else begin
        res.random_below = x % r.range_limit;
      end
      if (x == '0) n_zero_draws++;
      n_draws++;
    end
    expected_rsp_q.push_back(res);
  endtask

  task automatic queue_req(input logic act, input logic [PinBits-1:0] pins,
                           input logic [WordBits-1:0] stamp,
                           input logic [WordBits-1:0] lim);
    in_req_t r;
    r.action = act;
    r.pin_levels = pins;
    r.timestamp_us = stamp;
    r.range_limit = lim;
    pending_req_q.push_back(r);
  endtask

  task automatic queue_random_reqs(input int count);
    logic [WordBits-1:0] lim;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) < 2) begin
        case ($urandom_range(0, 9))
          0: lim = '0;
          1: lim = $urandom_range(1, 16);
          2: lim = 32'hFFFF_FFFF - $urandom_range(0, 3);
          3: lim = 32'h1 << $urandom_range(0, 31);
          default: lim = $urandom;
        endcase
        queue_req(ActDraw, PinBits'($urandom), $urandom, lim);
      end else begin
        case ($urandom_range(0, 9))
          0: stick_pins = PinBits'($urandom);
          1: stick_pins = '1;
          default: stick_pins ^= PinBits'(1) << $urandom_range(0, PinBits - 1);
        endcase
        if ($urandom_range(0, 7) == 0) begin
          stamp_clock = $urandom;
        end else begin
          stamp_clock += $urandom_range(1, 20000);
        end
        queue_req(ActPoll, stick_pins, stamp_clock, $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_req_q.size() != 0 || in_valid || expected_rsp_q.size() != 0);
  endtask

  // sender: bursts of requests separated by random gaps
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rng_result(in_req);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || pending_req_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_req <= pending_req_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: check results and stall on a pattern of its own
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with nothing expected", '0, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp.held !== want.held)
            report_mismatch("held", 32'(out_rsp.held), 32'(want.held));
          if (out_rsp.newly_pressed !== want.newly_pressed)
            report_mismatch("newly_pressed", 32'(out_rsp.newly_pressed),
                            32'(want.newly_pressed));
          if (out_rsp.random_value !== want.random_value)
            report_mismatch("random_value", out_rsp.random_value, want.random_value);
          if (out_rsp.random_below !== want.random_below)
            report_mismatch("random_below", out_rsp.random_below, want.random_below);
          if (out_rsp.range_error !== want.range_error)
            report_mismatch("range_error", 32'(out_rsp.range_error),
                            32'(want.range_error));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!holdoff_done && n_results >= 100) begin
        holdoff_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        if (stall_phase == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          stall_phase = $urandom_range(20, 120);
        end
        stall_phase--;
        case (stall_mode)
          StallNone:  out_stall <= 1'b0;
          StallLight: out_stall <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
          default:    out_stall <= stall_phase[1];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d cycles without a handshake", idle_cycles);
        $display("button_edge_xorshift_rng test failed");
        $finish;
      end
    end
  end

  initial begin
    queue_req(ActDraw, '1, '0, 32'd5);
    queue_req(ActPoll, '0, 32'hFFFF_FFFF, '0);
    queue_req(ActDraw, '1, '1, '0);
    queue_req(ActPoll, '1, '0, '1);
    queue_req(ActPoll, 10'h3FE, 32'h1234_5678, '0);
    queue_req(ActPoll, 10'h1FF, 32'hFFFF_FFFF, '0);
    queue_req(ActPoll, '0, '0, '0);
    queue_req(ActDraw, '0, '0, 32'd1);
    queue_req(ActDraw, '0, '0, 32'hFFFF_FFFF);
    queue_req(ActDraw, '0, '0, 32'h8000_0000);
    queue_req(ActPoll, '1, 32'd1, '0);
    queue_req(ActPoll, 10'h2F7, 32'hA5A5_5A5A, '0);
    queue_req(ActPoll, '1, '0, '0);

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // cancel the generator state with the next press
    wait_idle();
    queue_req(ActPoll, 10'h3FB, model_rng, '0);
    queue_req(ActDraw, '1, '1, 32'd3);
    queue_req(ActDraw, '1, '1, '0);
    queue_req(ActPoll, '1, '0, '0);
    queue_req(ActPoll, 10'h2FF, 32'hDEAD_BEEF, '0);
    queue_req(ActDraw, '1, '0, 32'd10);

    wait_idle();
    queue_random_reqs(400);
    wait_idle();
    queue_random_reqs(400);
    wait_idle();
    repeat (40) @(posedge clk_i);

    if (expected_rsp_q.size() != 0)
      report_mismatch("results never delivered", expected_rsp_q.size(), '0);
    $display("covered %0d polls (%0d mixed a timestamp in) and %0d draws, %0d results",
             n_polls, n_mixes, n_draws, n_results);
    $display("zero-range draws %0d, draws from a zero state %0d, mismatches %0d",
             n_zero_ranges, n_zero_draws, n_errors);
    if (n_errors == 0) begin
      $display("button_edge_xorshift_rng test passed");
    end else begin
      $display("button_edge_xorshift_rng test failed");
    end
    $finish;
  end

endmodule
